[src/fba_pkg.sv]
// Shared types, constants and helper functions for the frame bitmap allocator.
// No dependencies; imported by fba_word_store and frame_bitmap_allocator_unit.
package fba_pkg;

    // Bitmap word geometry
    localparam int unsigned WORD_BITS = 8;
    localparam int unsigned BIT_W     = 3;
    localparam logic [WORD_BITS-1:0] WORD_FULL = 8'hFF;

    // Address geometry
    localparam int unsigned PAGE_SHIFT = 12;
    localparam int unsigned ADDR_W     = 32;
    localparam int unsigned BASE_W     = ADDR_W - PAGE_SHIFT;
    localparam logic [BASE_W-1:0] BASE_RESET = 20'd4096;

    // Stream widths
    localparam int unsigned S_DATA_W = 8;
    localparam int unsigned M_DATA_W = ADDR_W;
    localparam int unsigned M_USER_W = 1;

    // Allocator sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOOK,
        S_PUSH
    } t_state;

    // Return the position of the lowest clear bit of a word (0 if none)
    function automatic logic [BIT_W-1:0] f_low_zero(input logic [WORD_BITS-1:0] word);
        logic [BIT_W-1:0] pos;
        pos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!word[i]) begin
                pos = BIT_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

[src/fba_word_store.sv]
// Bitmap word memory with one read and one write port and a fill count.
// Entries at or above the fill count were never written and read as zero.
// Depends on fba_pkg.
module fba_word_store #(
    parameter  int unsigned MAP_WORDS = 128,
    localparam int unsigned IW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_rd_en,
    input  logic [IW-1:0]                  i_rd_idx,
    input  logic                           i_wr_en,
    input  logic [IW-1:0]                  i_wr_idx,
    input  logic [fba_pkg::WORD_BITS-1:0]  i_wr_data,
    output logic [fba_pkg::WORD_BITS-1:0]  o_rd_data
);
    import fba_pkg::*;

    localparam int unsigned CW = $clog2(MAP_WORDS + 1);

    logic [WORD_BITS-1:0] r_mem [MAP_WORDS];
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_blank;
    logic [CW-1:0]        r_fill;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    // Read port, registered; flag entries never written
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_rd_blank <= (CW'(i_rd_idx) >= r_fill);
        end
    end

    // Advance the fill count when the first unwritten entry is written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_wr_en && (CW'(i_wr_idx) == r_fill)) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    assign o_rd_data = r_rd_blank ? '0 : r_rd_data;

`ifndef SYNTHESIS
    // Writes never skip past the fill count
    a_wr_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr_en |-> (CW'(i_wr_idx) <= r_fill))
        else $error("bitmap write beyond fill count");

    // Fill count stays within the memory
    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAP_WORDS))
        else $error("fill count out of range");

    // Never read and write the same entry in one cycle
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_wr_en && i_rd_en) |-> (i_wr_idx != i_rd_idx))
        else $error("read and write to the same entry");
`endif

endmodule

[src/frame_bitmap_allocator_unit.sv]
// First-fit page frame allocator: top level with request sequencer and output register.
// Depends on fba_pkg and fba_word_store.
//
// Usage:
//   Slave stream s_*: one transaction per request; s_tdata[0] is the reserve token.
//   A token of 1 reserves the lowest free frame; a token of 0 returns an empty result.
//   Master stream m_*: one transaction per request, in request order;
//   m_tdata is the frame byte address, m_tuser[0] flags that no frame was free
//   (address 0 then). The address is (area_base_page + frame index) << 12, mod 2^32.
//   Configuration: i_cfg_we writes i_cfg_wdata into area_base_page; write only when idle.
// Sequencing:
//   A reservation reads the word at the first-not-full pointer on acceptance, is
//   evaluated and written back in S_LOOK and reaches the output register from S_PUSH;
//   the pointer makes one read suffice. An empty or refused request goes straight
//   to S_PUSH. The sequencer returns to idle with the output load, so no new request
//   is taken before the last result is loaded, and a stalled output delays that load.
// Reset: the bitmap reads as all free at once (fill count cleared, no clearing pass),
//   area_base_page returns to 4096 and the output register empties.
// Stall: a stalled master side holds the result in the output register; the next
//   request is still accepted and evaluated, then waits until the output register drains.
module frame_bitmap_allocator_unit #(
    parameter int unsigned MAP_WORDS = 128
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Configuration
    input  logic                          i_cfg_we,
    input  logic [fba_pkg::BASE_W-1:0]    i_cfg_wdata,   // area_base_page
    // Request stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fba_pkg::S_DATA_W-1:0]  s_tdata,       // [0] reserve, [7:1] zero
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fba_pkg::M_DATA_W-1:0]  m_tdata,       // [31:0] frame_address
    output logic [fba_pkg::M_USER_W-1:0]  m_tuser        // [0] out_of_space
);
    import fba_pkg::*;

    localparam int unsigned IW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int unsigned CW = $clog2(MAP_WORDS + 1);
    localparam logic [CW-1:0] IDX_END  = CW'(MAP_WORDS);
    localparam logic [CW-1:0] IDX_LAST = CW'(MAP_WORDS - 1);

    t_state              r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic [CW-1:0]       r_hint, n_hint;
    logic [ADDR_W-1:0]   r_res_addr, n_res_addr;
    logic                r_res_oos, n_res_oos;
    logic [BASE_W-1:0]   r_base;
    logic                r_out_valid;
    logic [ADDR_W-1:0]   r_out_addr;
    logic                r_out_oos;

    logic [WORD_BITS-1:0] rd_word;
    logic [WORD_BITS-1:0] new_word;
    logic [BIT_W-1:0]     free_bit;
    logic                 word_full;
    logic [BASE_W-1:0]    frame_page;
    logic [CW-1:0]        idx_next;
    logic                 out_free;
    logic                 mem_rd_en;
    logic [IW-1:0]        mem_rd_idx;
    logic                 mem_we;

    // Bitmap storage
    fba_word_store #(
        .MAP_WORDS (MAP_WORDS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (mem_rd_en),
        .i_rd_idx  (mem_rd_idx),
        .i_wr_en   (mem_we),
        .i_wr_idx  (r_idx[IW-1:0]),
        .i_wr_data (new_word),
        .o_rd_data (rd_word)
    );

    // Pick the lowest free frame of the word just read
    assign word_full  = (rd_word == WORD_FULL);
    assign free_bit   = f_low_zero(rd_word);
    assign new_word   = rd_word | (WORD_BITS'(1) << free_bit);
    assign frame_page = r_base + BASE_W'({r_idx[IW-1:0], free_bit});
    assign idx_next   = CW'(r_idx + 1'b1);
    assign out_free   = !r_out_valid || m_tready;

    // Next state and scan bookkeeping
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_hint     = r_hint;
        n_res_addr = r_res_addr;
        n_res_oos  = r_res_oos;
        unique case (r_state)
            S_IDLE: begin
                if (s_tvalid) begin
                    if (!s_tdata[0] || (r_hint == IDX_END)) begin
                        n_res_addr = '0;
                        n_res_oos  = s_tdata[0];
                        n_state    = S_PUSH;
                    end else begin
                        n_idx   = r_hint;
                        n_state = S_LOOK;
                    end
                end
            end
            S_LOOK: begin
                if (word_full) begin
                    if (r_idx == IDX_LAST) begin
                        n_res_addr = '0;
                        n_res_oos  = 1'b1;
                        n_hint     = IDX_END;
                        n_state    = S_PUSH;
                    end else begin
                        n_idx = idx_next;
                    end
                end else begin
                    n_res_addr = {frame_page, PAGE_SHIFT'(0)};
                    n_res_oos  = 1'b0;
                    n_hint     = (new_word == WORD_FULL) ? idx_next : r_idx;
                    n_state    = S_PUSH;
                end
            end
            S_PUSH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Handshake and memory controls
    always_comb begin
        s_tready   = 1'b0;
        mem_rd_en  = 1'b0;
        mem_rd_idx = r_hint[IW-1:0];
        mem_we     = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                s_tready  = 1'b1;
                mem_rd_en = s_tvalid && s_tdata[0] && (r_hint != IDX_END);
            end
            S_LOOK: begin
                mem_rd_en  = word_full && (r_idx != IDX_LAST);
                mem_rd_idx = idx_next[IW-1:0];
                mem_we     = !word_full;
            end
            S_PUSH: begin
            end
            default: begin
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_hint  <= '0;
        end else begin
            r_state <= n_state;
            r_hint  <= n_hint;
        end
    end

    // Scan index and pending result
    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_res_addr <= n_res_addr;
        r_res_oos  <= n_res_oos;
    end

    // Area base register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= BASE_RESET;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Output register: load a finished result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_PUSH) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_PUSH) && out_free) begin
            r_out_addr <= r_res_addr;
            r_out_oos  <= r_res_oos;
        end
    end

    assign m_tvalid   = r_out_valid;
    assign m_tdata    = r_out_addr;
    assign m_tuser[0] = r_out_oos;

`ifndef SYNTHESIS
    // The scan never looks below the first-not-full pointer
    a_scan_from_hint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LOOK) |-> (r_idx >= r_hint) && (r_idx < IDX_END))
        else $error("scan index outside the live range");

    // A write-back only replaces a word that still had a free frame
    a_wb_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> (rd_word != WORD_FULL) && $onehot(new_word ^ rd_word))
        else $error("write-back does not set exactly one new bit");

    // An out-of-space result carries address zero
    a_oos_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
        else $error("out-of-space result with nonzero address");

    // Once every frame is taken the bitmap is no longer written; full is reported without a memory read
    a_full_no_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_hint == IDX_END) |-> !mem_we)
        else $error("bitmap written after it was full");
`endif

endmodule

[test/tb_frame_bitmap_allocator_unit.sv]
// Self-checking testbench for frame_bitmap_allocator_unit: first-fit frame reservation,
// area base writes, address wrap and the full-bitmap refusal, checked against a predictor.
// Depends on fba_pkg and the allocator RTL.
module tb_frame_bitmap_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fba_pkg::*;

    localparam int unsigned MAP_WORDS   = 128;
    localparam int unsigned GAP_MAX     = 16;
    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned REPORT_MAX  = 10;
    localparam int unsigned DRAIN_WAIT  = 4;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              oos;
    } t_frame_result;

    typedef enum logic {
        ROW_ITEM,
        ROW_CFG
    } t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [BASE_W-1:0] value;   // reserve token in bit 0 for items, base for writes
        bit                typed;
        t_frame_result     res;
    } t_dir_row;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_cfg_we    = 1'b0;
    logic [BASE_W-1:0]    i_cfg_wdata = '0;
    logic                 s_tvalid    = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata     = '0;    // [0] reserve, [7:1] zero
    logic                 m_tvalid;
    logic                 m_tready    = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;             // [31:0] frame_address
    logic [M_USER_W-1:0]  m_tuser;             // [0] out_of_space

    // Predictor state: own copy of the bitmap and the area base
    logic [WORD_BITS-1:0] frame_map [MAP_WORDS];
    logic [BASE_W-1:0]    area_base_model;
    t_frame_result        pending_results [$];
    t_dir_row             dir_rows [$];

    int unsigned src_idle_pct = 0;
    int unsigned rcv_idle_pct = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned idle_cycles  = 0;
    int unsigned request_cnt  = 0;
    int unsigned reserve_cnt  = 0;
    int unsigned refused_cnt  = 0;
    int unsigned checked_cnt  = 0;
    int unsigned cfg_writes   = 0;

    frame_bitmap_allocator_unit #(
        .MAP_WORDS(MAP_WORDS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Take the lowest free frame of the first non-full word, or refuse when full; no token gives an empty result
    task automatic predict_reservation(input bit req, output t_frame_result res);
        int unsigned w;
        int unsigned b;
        bit          done;
        logic [31:0] page;
        res  = '0;
        done = 1'b0;
        request_cnt++;
        if (!req) begin
            return;
        end
        reserve_cnt++;
        for (w = 0; w < MAP_WORDS && !done; w++) begin
            if (frame_map[w] != WORD_FULL) begin
                for (b = 0; b < WORD_BITS && !done; b++) begin
                    if (!frame_map[w][b]) begin
                        frame_map[w][b] = 1'b1;
                        page = 32'(area_base_model) + 32'(w * WORD_BITS + b);
                        res.addr = page << PAGE_SHIFT;
                        done = 1'b1;
                    end
                end
            end
        end
        if (!done) begin
            res.oos = 1'b1;
            refused_cnt++;
        end
    endtask

    // Present one request, hold it until accepted, then queue its expected frame
    task automatic send_request(input bit req, input bit typed, input t_frame_result typed_res);
        int unsigned   gap;
        t_frame_result res;
        gap = 0;
        while (gap < GAP_MAX && $urandom_range(0, 99) < src_idle_pct) gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_DATA_W'(req);
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        predict_reservation(req, res);
        if (typed) begin
            res = typed_res;
        end
        pending_results.push_back(res);
    endtask

    // Drain all outstanding frames, then write the area base while the block is idle
    task automatic write_area_base(input logic [BASE_W-1:0] value);
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we        <= 1'b0;
        area_base_model  = value;
        cfg_writes++;
    endtask

    task automatic add_row(input t_row_kind kind, input logic [BASE_W-1:0] value,
                           input bit typed, input logic [ADDR_W-1:0] addr, input logic oos);
        t_dir_row row;
        row.kind     = kind;
        row.value    = value;
        row.typed    = typed;
        row.res.addr = addr;
        row.res.oos  = oos;
        dir_rows.push_back(row);
    endtask

    // Compare each result transaction with the oldest expected frame; run the watchdog
    always @(posedge i_clk) begin : result_check
        t_frame_result want;
        if (!i_rst_n) begin
            idle_cycles = 0;
        end else begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (m_tvalid && m_tready) begin
                if (pending_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= REPORT_MAX) begin
                        $display("unexpected result: addr %h oos %0d", m_tdata, m_tuser[0]);
                    end
                end else begin
                    want = pending_results.pop_front();
                    checked_cnt++;
                    if (m_tdata !== want.addr || m_tuser[0] !== want.oos) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= REPORT_MAX) begin
                            $display("mismatch: expected addr %h oos %0d, got addr %h oos %0d",
                                     want.addr, want.oos, m_tdata, m_tuser[0]);
                        end
                    end
                end
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("CHECKS FAILED");
                $finish;
            end
        end
        // Stall the result side at random
        m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    initial begin : stimulus
        int unsigned   n;
        int unsigned   phase;
        t_frame_result none;
        none = '0;
        for (n = 0; n < MAP_WORDS; n++) frame_map[n] = '0;
        area_base_model = BASE_RESET;

        // Directed rows: reset base, zero base, top base with wrap, word boundary crossing
        add_row(ROW_ITEM, 20'd1, 1'b1, 32'h0100_0000, 1'b0);   // first frame after reset
        add_row(ROW_ITEM, 20'd0, 1'b1, 32'h0000_0000, 1'b0);   // no request
        add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);
        add_row(ROW_CFG,  20'h00000, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd0, 1'b1, 32'h0000_0000, 1'b0);
        add_row(ROW_CFG,  20'hFFFFF, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);              // page sum wraps past 2^20
        add_row(ROW_CFG,  20'hFFFFB, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd1, 1'b1, 32'hFFFF_F000, 1'b0);   // frame 4 lands on the top page
        add_row(ROW_ITEM, 20'd1, 1'b1, 32'h0000_0000, 1'b0);   // address wraps to zero
        add_row(ROW_CFG,  20'h00001, 1'b0, '0, 1'b0);
        repeat (5) add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);   // crosses into word 1
        add_row(ROW_ITEM, 20'd0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd0, 1'b0, '0, 1'b0);
        add_row(ROW_ITEM, 20'd1, 1'b0, '0, 1'b0);

        // Hold reset, then release
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct = 32;
        rcv_idle_pct = 84;
        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                write_area_base(dir_rows[i].value);
            end else begin
                send_request(dir_rows[i].value[0], dir_rows[i].typed, dir_rows[i].res);
            end
        end

        // Random phases: sender-idle-light, receiver-idle-light, then no idling.
        // Mostly reservations so the map fills and the refusal path gets a long run.
        for (phase = 0; phase < 3; phase++) begin
            unique case (phase)
                0: begin
                    write_area_base(BASE_W'($urandom_range(0, (1 << BASE_W) - 1)));
                    src_idle_pct = 32;
                    rcv_idle_pct = 84;
                end
                1: begin
                    write_area_base('1);
                    src_idle_pct = 84;
                    rcv_idle_pct = 32;
                end
                default: begin
                    write_area_base('0);
                    src_idle_pct = 0;
                    rcv_idle_pct = 0;
                end
            endcase
            n = 0;
            while (n < 425 || (phase == 2 && refused_cnt < 40)) begin
                send_request($urandom_range(0, 7) != 0, 1'b0, none);
                n++;
            end
        end

        // Wait out the remaining frames and the pipeline tail
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("run: %0d requests, %0d reservations, %0d refused on a full map",
                 request_cnt, reserve_cnt, refused_cnt);
        $display("run: %0d results checked, %0d base writes, %0d mismatches",
                 checked_cnt, cfg_writes, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
